// File: design/dual_key_best_fit_store_unit_defines.svh
// ----------------------------------------------------------------------------
// dual_key_best_fit_store_unit_defines
// assertion macros for the store unit
// ----------------------------------------------------------------------------
`ifndef DUAL_KEY_BEST_FIT_STORE_UNIT_DEFINES_SVH
`define DUAL_KEY_BEST_FIT_STORE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DKBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DKBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dkbf_pkg.sv
// ----------------------------------------------------------------------------
// dkbf_pkg
// constants, codes and types of the best-fit box store
// ----------------------------------------------------------------------------
package dkbf_pkg;

    // store size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // request kinds
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_TAKE_WT  = 2'd1;
    localparam logic [1:0] REQ_TAKE_VOL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [DATA_W-1:0] ID_MAX = {DATA_W{1'b1}};

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // one stored box, weight in the low bits
    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] volume;
        logic [DATA_W-1:0] weight;
    } t_entry;

endpackage

// File: design/dual_key_best_fit_store_unit.sv
// An add walks the valid marks up to the lowest free slot; a take scans the box memory
// one entry a cycle through a single shared compare unit.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset (synchronous, active low) clears the valid marks, the id counter and the output;
// the box memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// dual_key_best_fit_store_unit
// box store with add, and best-fit take by weight or by volume
// ----------------------------------------------------------------------------
`include "dual_key_best_fit_store_unit_defines.svh"

module dual_key_best_fit_store_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,  // box_weight[31:0], box_volume[63:32], threshold[95:64]
    input  logic [1:0]   i_s_axis_tuser,  // req_type[1:0]
    // result channel
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata,  // box_id[31:0]
    output logic [1:0]   o_m_axis_tuser   // status[1:0]
);

    localparam int CAP = dkbf_pkg::CAPACITY;
    localparam int IW  = dkbf_pkg::IDX_W;
    localparam int CW  = dkbf_pkg::CNT_W;
    localparam int DW  = dkbf_pkg::DATA_W;

    dkbf_pkg::t_state r_state;

    // box memory and valid marks
    dkbf_pkg::t_entry r_mem [CAP];
    dkbf_pkg::t_entry r_rd_data;
    logic [CAP-1:0]   r_valid;

    // request registers
    logic [DW-1:0]    r_wt;
    logic [DW-1:0]    r_vol;
    logic [DW-1:0]    r_thr;
    logic             r_by_vol;
    logic             r_is_take;
    logic [DW-1:0]    r_next_id;

    // scan state
    logic [CW-1:0]    r_idx;
    logic             r_pend;
    logic             r_pend_vld;
    logic             r_found;
    logic [DW-1:0]    r_best_key;
    logic [DW-1:0]    r_best_id;
    logic [IW-1:0]    r_best_slot;
    logic [IW-1:0]    r_pend_slot;
    logic [1:0]       r_res_st;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_out_st;
    logic [DW-1:0]    r_out_id;

    logic             in_xfer;
    logic             out_free;
    logic             idx_end;
    logic [IW-1:0]    slot;
    logic             mem_we;
    logic [DW-1:0]    cand_key;
    logic             cand_take;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign idx_end  = (r_idx == CW'(CAP));
    assign slot     = r_idx[IW-1:0];
    assign mem_we   = (r_state == dkbf_pkg::S_ADD) && !idx_end && !r_valid[slot];

    assign o_s_axis_tready = (r_state == dkbf_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_st;

    // shared compare unit: threshold test and best-so-far test on the entry just read
    always_comb begin
        cand_key  = r_by_vol ? r_rd_data.volume : r_rd_data.weight;
        cand_take = r_pend && r_pend_vld
                    && ($signed(cand_key) >= $signed(r_thr))
                    && (!r_found
                        || ($signed(cand_key) < $signed(r_best_key))
                        || ((cand_key == r_best_key) && (r_rd_data.id > r_best_id)));
    end

    // box memory, one write and one registered read per cycle at the scan slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[slot] <= '{id: r_next_id, volume: r_vol, weight: r_wt};
        end
        r_rd_data <= r_mem[slot];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dkbf_pkg::S_IDLE;
            r_valid     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_is_take   <= 1'b0;
        end else begin
            // output transfer drains the register unless a new result is loaded below
            if (r_out_valid && i_m_axis_tready && (r_state != dkbf_pkg::S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                dkbf_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        r_wt      <= i_s_axis_tdata[31:0];
                        r_vol     <= i_s_axis_tdata[63:32];
                        r_thr     <= i_s_axis_tdata[95:64];
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_pend    <= 1'b0;
                        r_by_vol  <= (i_s_axis_tuser == dkbf_pkg::REQ_TAKE_VOL);
                        r_is_take <= (i_s_axis_tuser == dkbf_pkg::REQ_TAKE_WT)
                                     || (i_s_axis_tuser == dkbf_pkg::REQ_TAKE_VOL);
                        case (i_s_axis_tuser)
                            dkbf_pkg::REQ_ADD: begin
                                if (r_next_id == dkbf_pkg::ID_MAX) begin
                                    r_res_st <= dkbf_pkg::ST_REFUSED;
                                    r_state  <= dkbf_pkg::S_FIN;
                                end else begin
                                    r_state <= dkbf_pkg::S_ADD;
                                end
                            end
                            dkbf_pkg::REQ_TAKE_WT,
                            dkbf_pkg::REQ_TAKE_VOL: begin
                                r_state <= dkbf_pkg::S_SCAN;
                            end
                            default: begin
                                r_res_st <= dkbf_pkg::ST_REFUSED;
                                r_state  <= dkbf_pkg::S_FIN;
                            end
                        endcase
                    end
                end
                // walk the valid marks up to the lowest free slot, refuse when none is free
                dkbf_pkg::S_ADD: begin
                    if (idx_end) begin
                        r_res_st <= dkbf_pkg::ST_REFUSED;
                        r_state  <= dkbf_pkg::S_FIN;
                    end else if (!r_valid[slot]) begin
                        r_valid[slot] <= 1'b1;
                        r_best_id     <= r_next_id;
                        r_found       <= 1'b1;
                        r_next_id     <= r_next_id + DW'(1);
                        r_res_st      <= dkbf_pkg::ST_OK;
                        r_state       <= dkbf_pkg::S_FIN;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                // read one entry a cycle, compare it the cycle after
                dkbf_pkg::S_SCAN: begin
                    if (!idx_end) begin
                        r_pend      <= 1'b1;
                        r_pend_vld  <= r_valid[slot];
                        r_pend_slot <= slot;
                        r_idx       <= r_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (cand_take) begin
                        r_found     <= 1'b1;
                        r_best_key  <= cand_key;
                        r_best_id   <= r_rd_data.id;
                        r_best_slot <= r_pend_slot;
                    end
                    if (idx_end && !r_pend) begin
                        r_res_st <= r_found ? dkbf_pkg::ST_OK : dkbf_pkg::ST_NONE;
                        r_state  <= dkbf_pkg::S_FIN;
                    end
                end
                // hand the result to the output register, drop the taken box
                dkbf_pkg::S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_res_st;
                        r_out_id    <= r_found ? r_best_id : '0;
                        if (r_is_take && r_found) begin
                            r_valid[r_best_slot] <= 1'b0;
                        end
                        r_state <= dkbf_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= dkbf_pkg::S_IDLE;
                end
            endcase
        end
    end

    // checks
    `DKBF_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_s_axis_tready, "ready held after a request transfer")
    `DKBF_ASSERT_NEXT(a_take_clears_slot, i_clk, i_rst_n, (r_state == dkbf_pkg::S_FIN) && r_is_take && r_found && out_free, !r_valid[r_best_slot], "taken box still marked valid")
    `DKBF_ASSERT_NOW(a_id_steps_by_one, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_next_id), r_next_id == ($past(r_next_id) + 32'd1), "id counter moved by other than one")

endmodule

// File: sim/tb_dual_key_best_fit_store_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_key_best_fit_store_unit
// self-checking bench for the best-fit box store: requests go in as bursts
// with random gaps, results are drained under a shifting stall pattern, and
// every result is compared with a box-table predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_dual_key_best_fit_store_unit;

    // request code with no meaning in the block
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
    localparam int          RANDOM_REQS = 1150;
    localparam int          DRAIN_TAIL  = dkbf_pkg::CAPACITY + 8;
    localparam int          RUN_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
    } t_box_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    // predicted box table
    logic               slot_used [dkbf_pkg::CAPACITY];
    logic signed [31:0] slot_wt   [dkbf_pkg::CAPACITY];
    logic signed [31:0] slot_vol  [dkbf_pkg::CAPACITY];
    logic [31:0]        slot_tag  [dkbf_pkg::CAPACITY];
    logic [31:0]        id_counter;

    t_box_result pending_results [$];
    int          mismatch_count = 0;
    int          result_index = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          rx_left = 0;
    t_rx_mode    rx_mode = RX_OPEN;

    dual_key_best_fit_store_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // box_weight[31:0], box_volume[63:32], threshold[95:64]
        .i_s_axis_tuser  (s_tuser),   // req_type[1:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // box_id[31:0]
        .o_m_axis_tuser  (o_m_axis_tuser)   // status[1:0]
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stall pattern, mode and its duration chosen at random
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_tready <= $urandom_range(0, 1);
            default:  m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result check on every transfer out of the block
    always @(posedge i_clk) begin
        t_box_result want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result %0d: no result expected, got status %0d id %0d",
                       result_index, o_m_axis_tuser, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    $error("result %0d status: expected %0d, actual %0d",
                           result_index, want.status, o_m_axis_tuser);
                    mismatch_count++;
                end
                if (o_m_axis_tdata !== want.id) begin
                    $error("result %0d box_id: expected %0d, actual %0d",
                           result_index, want.id, o_m_axis_tdata);
                    mismatch_count++;
                end
            end
            result_index++;
        end
    end

    function automatic void clear_table();
        for (int s = 0; s < dkbf_pkg::CAPACITY; s++) begin
            slot_used[s] = 1'b0;
        end
        id_counter = '0;
    endfunction

    function automatic int stored_count();
        int n;
        n = 0;
        for (int s = 0; s < dkbf_pkg::CAPACITY; s++) begin
            if (slot_used[s]) n++;
        end
        return n;
    endfunction

    // updates the box table for one request and returns the result it gives
    function automatic t_box_result apply_request(input logic [1:0] req,
                                                  input logic signed [31:0] wt,
                                                  input logic signed [31:0] vol,
                                                  input logic signed [31:0] thr);
        t_box_result        res;
        int                 hit;
        logic signed [31:0] key;
        logic signed [31:0] best;
        res.status = dkbf_pkg::ST_REFUSED;
        res.id = '0;
        hit = -1;
        best = '0;
        case (req)
            dkbf_pkg::REQ_ADD: begin
                // counter at its top refuses, as does a full table
                if (id_counter != dkbf_pkg::ID_MAX) begin
                    for (int s = 0; s < dkbf_pkg::CAPACITY && hit < 0; s++) begin
                        if (!slot_used[s]) hit = s;
                    end
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b1;
                        slot_wt[hit]   = wt;
                        slot_vol[hit]  = vol;
                        slot_tag[hit]  = id_counter;
                        res.status     = dkbf_pkg::ST_OK;
                        res.id         = id_counter;
                        id_counter     = id_counter + 1;
                    end
                end
            end
            dkbf_pkg::REQ_TAKE_WT, dkbf_pkg::REQ_TAKE_VOL: begin
                // smallest key at or above threshold, newest box on a tie
                res.status = dkbf_pkg::ST_NONE;
                for (int s = 0; s < dkbf_pkg::CAPACITY; s++) begin
                    if (slot_used[s]) begin
                        key = (req == dkbf_pkg::REQ_TAKE_VOL) ? slot_vol[s] : slot_wt[s];
                        if (key >= thr && (hit < 0 || key < best ||
                            (key == best && slot_tag[s] > slot_tag[hit]))) begin
                            hit  = s;
                            best = key;
                        end
                    end
                end
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    res.status     = dkbf_pkg::ST_OK;
                    res.id         = slot_tag[hit];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // key values weighted toward ties and signed corners
    function automatic logic [31:0] rand_key();
        logic [31:0] corners [6] = '{KEY_MIN, KEY_MIN + 1, 32'hFFFF_FFFF, 32'd0,
                                     KEY_MAX - 1, KEY_MAX};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 15) - 8;
            3:       return corners[$urandom_range(0, 5)];
            default: return $urandom();
        endcase
    endfunction

    // threshold near a stored key most of the time
    function automatic logic [31:0] pick_threshold(input logic by_vol);
        int used [$];
        int s;
        for (int k = 0; k < dkbf_pkg::CAPACITY; k++) begin
            if (slot_used[k]) used.push_back(k);
        end
        if (used.size() > 0 && $urandom_range(0, 9) < 6) begin
            s = used[$urandom_range(0, used.size() - 1)];
            return (by_vol ? slot_vol[s] : slot_wt[s]) + $urandom_range(0, 2) - 1;
        end
        return rand_key();
    endfunction

    // one request transfer; bursts of random length, sender often idles between them
    task automatic send_request(input logic [1:0] req, input logic [31:0] wt,
                                input logic [31:0] vol, input logic [31:0] thr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {thr, vol, wt};
        s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(apply_request(req, wt, vol, thr));
    endtask

    // takes from an empty table and an unknown request
    task automatic test_empty_and_unknown();
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), KEY_MIN);
        send_request(dkbf_pkg::REQ_TAKE_VOL, $urandom(), $urandom(), KEY_MIN);
        send_request(REQ_UNKNOWN, KEY_MAX, KEY_MIN, 32'hFFFF_FFFF);
        send_request(REQ_UNKNOWN, KEY_MIN, KEY_MAX, 32'd0);
    endtask

    // boxes at the signed corners, thresholds at the extremes
    task automatic test_extreme_keys();
        send_request(dkbf_pkg::REQ_ADD, KEY_MIN, KEY_MAX, 32'd0);
        send_request(dkbf_pkg::REQ_ADD, KEY_MAX, KEY_MIN, 32'hFFFF_FFFF);
        send_request(dkbf_pkg::REQ_ADD, 32'd0, 32'hFFFF_FFFF, KEY_MIN);
        send_request(dkbf_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'd0, KEY_MAX);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), KEY_MAX);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), KEY_MAX);
        send_request(dkbf_pkg::REQ_TAKE_VOL, $urandom(), $urandom(), KEY_MIN);
        send_request(dkbf_pkg::REQ_TAKE_VOL, $urandom(), $urandom(), 32'd1);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), KEY_MIN);
        send_request(dkbf_pkg::REQ_TAKE_VOL, $urandom(), $urandom(), KEY_MIN);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), KEY_MIN);
    endtask

    // equal keys: the newest box must be taken first
    task automatic test_ties();
        send_request(dkbf_pkg::REQ_ADD, 32'd5, 32'd7, $urandom());
        send_request(dkbf_pkg::REQ_ADD, 32'd5, 32'd7, $urandom());
        send_request(dkbf_pkg::REQ_ADD, 32'd5, 32'd9, $urandom());
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), 32'd5);
        send_request(dkbf_pkg::REQ_TAKE_VOL, $urandom(), $urandom(), 32'd6);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), 32'd6);
        send_request(dkbf_pkg::REQ_TAKE_WT, $urandom(), $urandom(), 32'hFFFF_FFFB);
    endtask

    // fill every slot, add to the full table, then drain it
    task automatic test_full_store();
        while (stored_count() < dkbf_pkg::CAPACITY) begin
            send_request(dkbf_pkg::REQ_ADD, rand_key(), rand_key(), $urandom());
        end
        send_request(dkbf_pkg::REQ_ADD, KEY_MAX, KEY_MIN, $urandom());
        send_request(dkbf_pkg::REQ_ADD, $urandom(), $urandom(), $urandom());
        while (stored_count() > 0) begin
            send_request($urandom_range(0, 1) ? dkbf_pkg::REQ_TAKE_VOL
                                              : dkbf_pkg::REQ_TAKE_WT,
                         $urandom(), $urandom(), KEY_MIN);
        end
    endtask

    // mixed traffic; add share shifts so the table swings between empty and full.
    // the id counter cannot reach its top within a run, the predictor still models it
    task automatic test_random_traffic(input int n_reqs);
        int          add_pct;
        int          pick;
        logic        by_vol;
        add_pct = 50;
        for (int i = 0; i < n_reqs; i++) begin
            if (i % 50 == 0) add_pct = $urandom_range(20, 85);
            pick = $urandom_range(0, 99);
            by_vol = $urandom_range(0, 1);
            if (pick < 3) begin
                send_request(REQ_UNKNOWN, $urandom(), $urandom(), $urandom());
            end else if (pick < add_pct) begin
                send_request(dkbf_pkg::REQ_ADD, rand_key(), rand_key(), $urandom());
            end else begin
                send_request(by_vol ? dkbf_pkg::REQ_TAKE_VOL : dkbf_pkg::REQ_TAKE_WT,
                             $urandom(), $urandom(), pick_threshold(by_vol));
            end
        end
    endtask

    // sequence of tests
    initial begin
        clear_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_unknown();
        test_extreme_keys();
        test_ties();
        test_full_store();
        test_random_traffic(RANDOM_REQS);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
